// File: hw/rtl/ribs_pkg.sv
// Package: shared widths and request codes for the region index search block.
`default_nettype none

package ribs_pkg;

  localparam int unsigned POS_W   = 32;  // start and query position width
  localparam int unsigned SLOT_W  = 8;   // load slot field width
  localparam int unsigned CNT_W   = 9;   // entry count register width
  localparam int unsigned RIDX_W  = 8;   // result index field width

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [RIDX_W-1:0] ridx_t;

  // req_type codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

endpackage : ribs_pkg

`default_nettype wire

// File: hw/rtl/region_index_binary_search_top.sv
// Top level: region start table with a binary predecessor search.
`default_nettype none

// Region index search. The block keeps a table of MAX_ENTRIES region start
// positions in one synchronous RAM (one write port, one registered read
// port). A load transaction (req_type = load) writes entry_start into slot
// entry_slot in the cycle it is accepted and produces no result; slots at or
// above MAX_ENTRIES are dropped. A query transaction binary-searches the first
// entry_count entries (entry_count above MAX_ENTRIES saturates) and returns
// the index of the last entry whose start is not above query_pos, or 0 when
// query_pos lies below entry 0. With entry_count zero the result carries
// empty_error = 1 and region_index = 0. The table must be ascending for the
// answer to mean anything; entries must be loaded before a query may reach
// them, as the RAM has no reset. A query on an empty table goes straight to
// the finish state; otherwise each halving step first issues the RAM read at
// the midpoint and then compares the returned start against the position.
// The search works on one query at a time; in_ready is low while it runs,
// and stays low for as long as the previous result still waits in the output
// register when the search finishes. Results sit in an output register, so a
// finished result waiting on out_ready does not stop the next transaction
// being accepted. entry_count is written through cfg_we/cfg_wdata and must
// only be changed while the block is idle.

module region_index_binary_search_top #(
  parameter int unsigned MAX_ENTRIES = 256
) (
  input  wire                  clk,
  input  wire                  rst,
  // configuration
  input  wire                  cfg_we,
  input  wire ribs_pkg::cnt_t  cfg_wdata,
  // request channel
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire                  req_type,
  input  wire ribs_pkg::slot_t entry_slot,
  input  wire ribs_pkg::pos_t  entry_start,
  input  wire ribs_pkg::pos_t  query_pos,
  // result channel
  output logic                 out_valid,
  input  wire                  out_ready,
  output ribs_pkg::ridx_t      region_index,
  output logic                 empty_error
);
  import ribs_pkg::*;

  // RAM address width, and the width of the search bounds (must hold
  // both a saturated count and any RAM address).
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned XW = (AW > CNT_W) ? AW : CNT_W;
  localparam logic [XW:0] MAX_V = (XW+1)'(MAX_ENTRIES);

  // sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SRCH   = 2'd1;  // issue read at midpoint
  localparam logic [1:0] S_CMP    = 2'd2;  // compare returned start
  localparam logic [1:0] S_FINISH = 2'd3;  // hand result to output register

  logic [1:0]    state;
  cnt_t          entry_count;
  pos_t          pos_q;
  logic [XW-1:0] lo;
  logic [XW-1:0] hi;
  logic [XW-1:0] mid_q;
  logic          err_q;

  // start table
  pos_t          start_table [MAX_ENTRIES];
  pos_t          rd_data;
  logic          mem_we;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  logic          in_fire;
  logic [XW-1:0] slot_x;
  logic [XW:0]   cnt_x;
  logic [XW:0]   cnt_sat;
  logic [XW:0]   cnt_m1;
  logic [XW:0]   mid_sum;
  logic [XW-1:0] mid;
  logic          out_load;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // load path: write straight into the RAM, drop slots beyond the table
  assign slot_x  = XW'(entry_slot);
  assign mem_we  = in_fire && (req_type == REQ_LOAD) && ({1'b0, slot_x} < MAX_V);
  assign wr_addr = slot_x[AW-1:0];

  // saturated count and upper bound
  assign cnt_x   = (XW+1)'(entry_count);
  assign cnt_sat = (cnt_x > MAX_V) ? MAX_V : cnt_x;
  assign cnt_m1  = cnt_sat - (XW+1)'(1);

  // midpoint rounds up, as lo moves to mid
  assign mid_sum = {1'b0, lo} + {1'b0, hi} + (XW+1)'(1);
  assign mid     = mid_sum[XW:1];
  assign rd_addr = mid[AW-1:0];

  assign out_load = (state == S_FINISH) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      start_table[wr_addr] <= entry_start;
    end
    rd_data <= start_table[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_we) begin
      entry_count <= cfg_wdata;
    end
  end

  // search sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire && (req_type == REQ_QUERY)) begin
            pos_q <= query_pos;
            lo    <= '0;
            if (cnt_sat == '0) begin
              hi    <= '0;
              err_q <= 1'b1;
              state <= S_FINISH;
            end else begin
              hi    <= cnt_m1[XW-1:0];
              err_q <= 1'b0;
              state <= S_SRCH;
            end
          end
        end
        S_SRCH: begin
          if (lo < hi) begin
            mid_q <= mid;
            state <= S_CMP;
          end else begin
            state <= S_FINISH;
          end
        end
        S_CMP: begin
          if (pos_q >= rd_data) begin
            lo <= mid_q;
          end else begin
            hi <= mid_q - XW'(1);
          end
          state <= S_SRCH;
        end
        S_FINISH: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      region_index <= lo[RIDX_W-1:0];
      empty_error  <= err_q;
    end
  end

endmodule : region_index_binary_search_top

`default_nettype wire

// File: hw/rtl/ribs_checker.sv
// Checker: port-level assertions for the region index search block, with bind.
`default_nettype none

module ribs_checker (
  input wire                  clk,
  input wire                  rst,
  input wire                  in_valid,
  input wire                  in_ready,
  input wire                  req_type,
  input wire                  out_valid,
  input wire                  out_ready,
  input wire ribs_pkg::ridx_t region_index,
  input wire                  empty_error
);
  import ribs_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(region_index) && $stable(empty_error))
    else $error("result changed while stalled");

  // empty table error always reports index 0
  a_err_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_error |-> region_index == '0)
    else $error("error result with non-zero index");

  // a query occupies the search: no new transaction next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (req_type == REQ_QUERY) |=> !in_ready)
    else $error("transaction accepted during search");

  // a load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (req_type == REQ_LOAD) && !out_valid |=> !out_valid)
    else $error("result raised by a load");

endmodule : ribs_checker

bind region_index_binary_search_top ribs_checker u_ribs_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .req_type     (req_type),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .region_index (region_index),
  .empty_error  (empty_error)
);

`default_nettype wire
